>>> sv/dvfs_level_governor_top_assert.svh
// Assertion macros for the DVFS level governor top level.
// Used only by dvfs_level_governor_top; needs clk and rst_n in scope.
`ifndef DVFS_LEVEL_GOVERNOR_TOP_ASSERT_SVH
`define DVFS_LEVEL_GOVERNOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DLG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvfs governor assertion failed");
`define DLG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvfs governor assertion failed");
`else
`define DLG_ASSERT_IMP(lbl, ante, cons)
`define DLG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/dlg_pkg.sv
// Shared types and constants of the DVFS level governor.
// No dependencies.
`timescale 1ns / 1ps
package dlg_pkg;
  localparam int LEVELS        = 16;
  localparam int LVL_W         = $clog2(LEVELS);
  localparam int HIST_DEPTH    = 8;
  localparam int HIST_W        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int MCU_DENOM     = 4;
  localparam int PCT_W         = 7;
  localparam int HYST_W        = 15;
  localparam int CLK_W         = 32;
  localparam int TOT_W         = 8;
  localparam int DIVISOR       = 100;
  localparam int FULL_LOAD     = 95;

  // x / 100 == (x * DIV100_MUL) >> DIV100_SH for any 32-bit x
  localparam logic [31:0] DIV100_MUL = 32'h51EB_851F;
  localparam int          DIV100_SH  = 37;
  // y / 100 == (y * SMALL_MUL) >> SMALL_SH for y below 43690
  localparam logic [12:0] SMALL_MUL  = 13'd5243;
  localparam int          SMALL_SH   = 19;

  localparam logic [1:0] MODE_BASIC = 2'd0;
  localparam logic [1:0] MODE_QUICK = 2'd1;
  localparam logic [1:0] MODE_QMCU  = 2'd2;
  localparam logic [1:0] MODE_HIST  = 2'd3;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_FASTEST   = 3'd1;
  localparam logic [2:0] REG_SLOWEST   = 3'd2;
  localparam logic [2:0] REG_STEP_UP   = 3'd3;
  localparam logic [2:0] REG_MCU_NUM   = 3'd4;
  localparam logic [2:0] REG_HEADROOM  = 3'd5;
  localparam logic [2:0] REG_CLAMP_FST = 3'd6;
  localparam logic [2:0] REG_CLAMP_SLW = 3'd7;

  typedef struct packed {
    logic [HYST_W-1:0] hyst;
    logic [PCT_W-1:0]  mcu_max;
    logic [PCT_W-1:0]  mcu_min;
    logic [PCT_W-1:0]  gpu_hi;
    logic [PCT_W-1:0]  gpu_lo;
  } entry_t;
endpackage

>>> sv/dlg_table.sv
// Level table: per-level bounds, hysteresis and clock, one write and one read port.
// Depends on dlg_pkg. Read data is registered.
`timescale 1ns / 1ps
module dlg_table (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [dlg_pkg::LVL_W-1:0]   wr_addr,
  input  dlg_pkg::entry_t             wr_entry,
  input  logic [dlg_pkg::CLK_W-1:0]   wr_clock,
  input  logic [dlg_pkg::LVL_W-1:0]   rd_addr,
  output dlg_pkg::entry_t             rd_entry,
  output logic [dlg_pkg::CLK_W-1:0]   rd_clock
);
  dlg_pkg::entry_t           ent_mem [dlg_pkg::LEVELS];
  logic [dlg_pkg::CLK_W-1:0] clk_mem [dlg_pkg::LEVELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_entry;
      clk_mem[wr_addr] <= wr_clock;
    end
    rd_entry <= ent_mem[rd_addr];
    rd_clock <= clk_mem[rd_addr];
  end
endmodule

>>> sv/dlg_div.sv
// History capacity unit: floor(clock * total / 100) truncated to 32 bits.
// Depends on dlg_pkg. Reciprocal multiplies step through phases ph_r[0] to ph_r[2]; done pulses after the last phase.
`timescale 1ns / 1ps
module dlg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dlg_pkg::CLK_W-1:0]     clock_in,
  input  logic [dlg_pkg::TOT_W-1:0]     total_in,
  output logic                          done,
  output logic [dlg_pkg::CLK_W-1:0]     quotient
);
  localparam int CW = dlg_pkg::CLK_W;
  localparam int TW = dlg_pkg::TOT_W;

  logic [2:0]      ph_r, ph_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   x_r, x_nxt, a_r, a_nxt, at_r, at_nxt, q_r, q_nxt;
  logic [TW-1:0]   t_r, t_nxt;
  logic [14:0]     y_r, y_nxt;
  logic [2*CW-1:0] recip_prod;
  logic [CW-1:0]   rem;
  logic [28:0]     small_prod;

  // clock = 100*a + b, so clock*total/100 = a*total + b*total/100
  assign recip_prod = (2*CW)'(x_r) * (2*CW)'(dlg_pkg::DIV100_MUL);
  assign rem        = x_r - CW'(a_r * CW'(dlg_pkg::DIVISOR));
  assign small_prod = 29'(y_r) * 29'(dlg_pkg::SMALL_MUL);
  assign done       = done_r;
  assign quotient   = q_r;

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    t_nxt    = t_r;
    a_nxt    = a_r;
    at_nxt   = at_r;
    y_nxt    = y_r;
    q_nxt    = q_r;
    if (start) begin
      x_nxt  = clock_in;
      t_nxt  = total_in;
      ph_nxt = 3'b001;
    end else if (ph_r[0]) begin
      a_nxt  = CW'(recip_prod >> dlg_pkg::DIV100_SH);
      ph_nxt = 3'b010;
    end else if (ph_r[1]) begin
      y_nxt  = 15'(rem[6:0]) * 15'(t_r);
      at_nxt = CW'(a_r * CW'(t_r));
      ph_nxt = 3'b100;
    end else if (ph_r[2]) begin
      q_nxt    = at_r + CW'(small_prod >> dlg_pkg::SMALL_SH);
      done_nxt = 1'b1;
      ph_nxt   = 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    x_r  <= x_nxt;
    t_r  <= t_nxt;
    a_r  <= a_nxt;
    at_r <= at_nxt;
    y_r  <= y_nxt;
    q_r  <= q_nxt;
  end
endmodule

>>> sv/dvfs_level_governor_top.sv
// DVFS level governor top level: sequencer, configuration registers and result port.
// Depends on dlg_pkg, dlg_table, dlg_div and dvfs_level_governor_top_assert.svh.
//
// Level 0 is the fastest. A table write (in_op 0) does not raise busy and
// answers with the current level on the next cycle. An evaluation walks the
// level table through its single read port, each access passing through a
// read state (S_RD0, S_RD1 or S_LKW) before its data is used: modes 0 and 1
// step through S_RD0, S_EVAL, S_RD1, S_HYST, S_FIN; mode 2 adds a headroom
// lookup (S_LKW, S_LK per level searched) if headroom is nonzero; mode 3 runs
// S_RD0, S_EVAL, a divide by 100 (S_DIV), a scan of all eight history entries
// (S_SCAN), the lookup and S_FIN, skipping scan and lookup on a full-load
// sample. Each result appears with out_valid for exactly one cycle, the first
// cycle with busy low; the receiver cannot stall it, so it must take it then.
`timescale 1ns / 1ps
`include "dvfs_level_governor_top_assert.svh"
module dvfs_level_governor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [3:0]                    in_entry_index,
  input  logic [6:0]                    in_entry_util_min,
  input  logic [6:0]                    in_entry_util_max,
  input  logic [6:0]                    in_entry_mcu_min,
  input  logic [6:0]                    in_entry_mcu_max,
  input  logic [14:0]                   in_entry_hysteresis,
  input  logic [31:0]                   in_entry_clock,
  input  logic [6:0]                    in_gpu_util,
  input  logic [6:0]                    in_mcu_util,
  output logic                          out_valid,
  output logic [3:0]                    out_next_level,
  output logic [3:0]                    out_raw_level,
  output logic                          out_was_clamped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  localparam int LW = dlg_pkg::LVL_W;
  localparam int HW = dlg_pkg::HIST_W;
  localparam int CW = dlg_pkg::CLK_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_EVAL = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_HYST = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_LKW  = 4'd7;
  localparam logic [3:0] S_LK   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  localparam logic [1:0] DLY_FULL = 2'd0;
  localparam logic [1:0] DLY_HALF = 2'd1;
  localparam logic [1:0] DLY_KEEP = 2'd2;

  // configuration
  logic [1:0]  mode_r;
  logic [LW-1:0] fastest_r, slowest_r, step_r, cfast_r, cslow_r;
  logic [7:0]  mcu_num_r;
  logic [CW-1:0] headroom_r;

  // sequencer state
  logic [3:0]    state_r, state_nxt;
  logic [LW-1:0] cur_r, cur_nxt, pre_r, pre_nxt, lvl_r, lvl_nxt, addr_r, addr_nxt;
  logic [LW-1:0] raw_r, raw_nxt, lk_r, lk_nxt;
  logic signed [15:0] dly_r, dly_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [6:0]    util_r, util_nxt, mcu_r, mcu_nxt;
  logic [CW-1:0] cap_r, cap_nxt, tgt_r, tgt_nxt;
  logic [HW-1:0] slot_r, slot_nxt, sc_r, sc_nxt;
  logic [CW-1:0] hist_r [dlg_pkg::HIST_DEPTH];
  logic          hist_we;
  logic          ov_r, ov_nxt;
  logic [LW-1:0] onl_r, onl_nxt, oraw_r, oraw_nxt;
  logic          ocl_r, ocl_nxt;

  dlg_pkg::entry_t wr_entry, rd_entry;
  logic [CW-1:0]   rd_clock;
  logic            tbl_we;
  logic            accept;
  logic            div_start, div_done;
  logic [CW-1:0]   div_q;
  logic [dlg_pkg::TOT_W-1:0]      total;

  // stepper terms
  logic          over, under, big, mode2;
  logic [7:0]    big_util;
  logic [14:0]   mcu_lim;
  logic signed [15:0] dec;
  logic [CW-1:0] scan_max;
  logic [LW-1:0] c1, cres;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign tbl_we    = accept && !in_op;
  assign total     = dlg_pkg::TOT_W'(util_r) + dlg_pkg::TOT_W'(mcu_r);
  assign out_valid       = ov_r;
  assign out_next_level  = onl_r;
  assign out_raw_level   = oraw_r;
  assign out_was_clamped = ocl_r;

  always_comb begin
    wr_entry.gpu_lo   = in_entry_util_min;
    wr_entry.gpu_hi   = in_entry_util_max;
    wr_entry.mcu_min  = in_entry_mcu_min;
    wr_entry.mcu_max  = in_entry_mcu_max;
    wr_entry.hyst     = in_entry_hysteresis;
  end

  dlg_table u_table (
    .clk      (clk),
    .wr_en    (tbl_we),
    .wr_addr  (in_entry_index),
    .wr_entry (wr_entry),
    .wr_clock (in_entry_clock),
    .rd_addr  (addr_r),
    .rd_entry (rd_entry),
    .rd_clock (rd_clock)
  );

  dlg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .clock_in (rd_clock),
    .total_in (total),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    mode2    = (mode_r == dlg_pkg::MODE_QMCU);
    over     = (util_r > rd_entry.gpu_hi) || (mode2 && (mcu_r > rd_entry.mcu_max));
    under    = (util_r < rd_entry.gpu_lo) && (!mode2 || (mcu_r < rd_entry.mcu_min));
    big_util = (8'd100 + 8'(rd_entry.gpu_hi)) >> 1;
    mcu_lim  = 15'(mcu_num_r) * 15'(rd_entry.mcu_max / dlg_pkg::MCU_DENOM);
    big      = (mode_r != dlg_pkg::MODE_BASIC) && (lvl_r >= step_r) &&
               ((8'(util_r) > big_util) || (mode2 && (15'(mcu_r) > mcu_lim)));
    dec      = dly_r - 16'sd1;
    scan_max = (tgt_r < hist_r[sc_r]) ? hist_r[sc_r] : tgt_r;
    c1       = (raw_r < cfast_r) ? cfast_r : raw_r;
    cres     = (c1 > cslow_r) ? cslow_r : c1;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pre_nxt   = pre_r;
    lvl_nxt   = lvl_r;
    addr_nxt  = addr_r;
    raw_nxt   = raw_r;
    lk_nxt    = lk_r;
    dly_nxt   = dly_r;
    kind_nxt  = kind_r;
    util_nxt  = util_r;
    mcu_nxt   = mcu_r;
    cap_nxt   = cap_r;
    tgt_nxt   = tgt_r;
    slot_nxt  = slot_r;
    sc_nxt    = sc_r;
    hist_we   = 1'b0;
    div_start = 1'b0;
    ov_nxt    = 1'b0;
    onl_nxt   = onl_r;
    oraw_nxt  = oraw_r;
    ocl_nxt   = ocl_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_op) begin
            ov_nxt   = 1'b1;
            onl_nxt  = cur_r;
            oraw_nxt = cur_r;
            ocl_nxt  = 1'b0;
          end else begin
            util_nxt  = in_gpu_util;
            mcu_nxt   = in_mcu_util;
            lvl_nxt   = mode2 ? pre_r : cur_r;
            addr_nxt  = mode2 ? pre_r : cur_r;
            state_nxt = S_RD0;
          end
        end
      end
      S_RD0: state_nxt = S_EVAL;
      S_EVAL: begin
        if (mode_r == dlg_pkg::MODE_HIST) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          kind_nxt = DLY_FULL;
          if ((lvl_r > fastest_r) && over) begin
            lvl_nxt  = big ? (lvl_r - step_r) : (lvl_r - 1'b1);
            kind_nxt = big ? DLY_HALF : DLY_FULL;
          end else if ((lvl_r < slowest_r) && under) begin
            dly_nxt = dec;
            if ((mode_r == dlg_pkg::MODE_BASIC) ? (dec == 16'sd0) : (dec <= 16'sd0)) begin
              lvl_nxt = lvl_r + 1'b1;
            end else begin
              kind_nxt = DLY_KEEP;
            end
          end
          addr_nxt  = lvl_nxt;
          state_nxt = S_RD1;
        end
      end
      S_RD1: state_nxt = S_HYST;
      S_HYST: begin
        case (kind_r)
          DLY_FULL: dly_nxt = 16'($unsigned(rd_entry.hyst));
          DLY_HALF: dly_nxt = 16'($unsigned(rd_entry.hyst >> 1));
          default:  dly_nxt = dly_r;
        endcase
        raw_nxt   = lvl_r;
        state_nxt = S_FIN;
        if (mode2) begin
          pre_nxt = lvl_r;
          if (headroom_r != '0) begin
            cap_nxt   = rd_clock + headroom_r;
            lk_nxt    = slowest_r;
            addr_nxt  = slowest_r;
            state_nxt = S_LKW;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          hist_we  = 1'b1;
          slot_nxt = (slot_r == HW'(dlg_pkg::HIST_DEPTH - 1)) ? '0 : (slot_r + 1'b1);
          if (total > dlg_pkg::TOT_W'(dlg_pkg::FULL_LOAD)) begin
            raw_nxt   = fastest_r;
            state_nxt = S_FIN;
          end else begin
            sc_nxt    = '0;
            tgt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        tgt_nxt = scan_max;
        if (sc_r == HW'(dlg_pkg::HIST_DEPTH - 1)) begin
          cap_nxt   = scan_max + headroom_r;
          lk_nxt    = slowest_r;
          addr_nxt  = slowest_r;
          state_nxt = S_LKW;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      S_LKW: state_nxt = S_LK;
      S_LK: begin
        // walk from the slowest level toward the fastest
        if (lk_r < fastest_r) begin
          raw_nxt   = fastest_r;
          state_nxt = S_FIN;
        end else if (rd_clock >= cap_r) begin
          raw_nxt   = lk_r;
          state_nxt = S_FIN;
        end else if (lk_r == '0) begin
          raw_nxt   = fastest_r;
          state_nxt = S_FIN;
        end else begin
          lk_nxt    = lk_r - 1'b1;
          addr_nxt  = lk_r - 1'b1;
          state_nxt = S_LKW;
        end
      end
      S_FIN: begin
        cur_nxt   = cres;
        ov_nxt    = 1'b1;
        onl_nxt   = cres;
        oraw_nxt  = raw_r;
        ocl_nxt   = (cres != raw_r);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= dlg_pkg::MODE_BASIC;
      fastest_r  <= '0;
      slowest_r  <= 4'd15;
      step_r     <= 4'd2;
      mcu_num_r  <= 8'd5;
      headroom_r <= '0;
      cfast_r    <= '0;
      cslow_r    <= 4'd15;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dlg_pkg::REG_MODE:      mode_r     <= cfg_data[1:0];
        dlg_pkg::REG_FASTEST:   fastest_r  <= cfg_data[3:0];
        dlg_pkg::REG_SLOWEST:   slowest_r  <= cfg_data[3:0];
        dlg_pkg::REG_STEP_UP:   step_r     <= cfg_data[3:0];
        dlg_pkg::REG_MCU_NUM:   mcu_num_r  <= cfg_data[7:0];
        dlg_pkg::REG_HEADROOM:  headroom_r <= cfg_data;
        dlg_pkg::REG_CLAMP_FST: cfast_r    <= cfg_data[3:0];
        dlg_pkg::REG_CLAMP_SLW: cslow_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= 4'd15;
      pre_r   <= 4'd15;
      dly_r   <= '0;
      slot_r  <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < dlg_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      pre_r   <= pre_nxt;
      dly_r   <= dly_nxt;
      slot_r  <= slot_nxt;
      ov_r    <= ov_nxt;
      if (hist_we) begin
        hist_r[slot_r] <= div_q;
      end
    end
    lvl_r  <= lvl_nxt;
    addr_r <= addr_nxt;
    raw_r  <= raw_nxt;
    lk_r   <= lk_nxt;
    kind_r <= kind_nxt;
    util_r <= util_nxt;
    mcu_r  <= mcu_nxt;
    cap_r  <= cap_nxt;
    tgt_r  <= tgt_nxt;
    sc_r   <= sc_nxt;
    onl_r  <= onl_nxt;
    oraw_r <= oraw_nxt;
    ocl_r  <= ocl_nxt;
  end

  `DLG_ASSERT_NXT(a_accept_responds, start && !busy, busy || out_valid)
  `DLG_ASSERT_NXT(a_fin_strobes, state_r == S_FIN, out_valid && !busy)
  `DLG_ASSERT_IMP(a_clamp_flag, out_valid && !out_was_clamped, out_next_level == out_raw_level)
endmodule
